/* rtl/ecu_pkg.sv */
// Package: shared types, codes and microprograms for the sensor compensation unit
`timescale 1ns / 1ps
package ecu_pkg;

    localparam logic [1:0] KIND_TEMP = 2'd0;
    localparam logic [1:0] KIND_PRES = 2'd1;
    localparam logic [1:0] KIND_HUM  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [2:0] CFG_TEMP   = 3'd0;
    localparam logic [2:0] CFG_PRES_A = 3'd1;
    localparam logic [2:0] CFG_PRES_B = 3'd2;
    localparam logic [2:0] CFG_PRES_C = 3'd3;
    localparam logic [2:0] CFG_HUM_A  = 3'd4;
    localparam logic [2:0] CFG_HUM_B  = 3'd5;

    localparam logic [3:0] OP_LDC  = 4'd0;
    localparam logic [3:0] OP_LDI  = 4'd1;
    localparam logic [3:0] OP_ADD  = 4'd2;
    localparam logic [3:0] OP_SUB  = 4'd3;
    localparam logic [3:0] OP_ADDI = 4'd4;
    localparam logic [3:0] OP_SUBI = 4'd5;
    localparam logic [3:0] OP_SHL  = 4'd6;
    localparam logic [3:0] OP_ASR  = 4'd7;
    localparam logic [3:0] OP_W32  = 4'd8;
    localparam logic [3:0] OP_MUL  = 4'd9;
    localparam logic [3:0] OP_DIV  = 4'd10;
    localparam logic [3:0] OP_CHKZ = 4'd11;
    localparam logic [3:0] OP_SATP = 4'd12;
    localparam logic [3:0] OP_CLMP = 4'd13;
    localparam logic [3:0] OP_STF  = 4'd14;
    localparam logic [3:0] OP_END  = 4'd15;

    localparam logic [47:0] C_RAW  = 48'd0;
    localparam logic [47:0] C_FINE = 48'd1;
    localparam logic [47:0] C_T1   = 48'd2;
    localparam logic [47:0] C_T2   = 48'd3;
    localparam logic [47:0] C_T3   = 48'd4;
    localparam logic [47:0] C_P1   = 48'd5;
    localparam logic [47:0] C_P2   = 48'd6;
    localparam logic [47:0] C_P3   = 48'd7;
    localparam logic [47:0] C_P4   = 48'd8;
    localparam logic [47:0] C_P5   = 48'd9;
    localparam logic [47:0] C_P6   = 48'd10;
    localparam logic [47:0] C_P7   = 48'd11;
    localparam logic [47:0] C_P8   = 48'd12;
    localparam logic [47:0] C_P9   = 48'd13;
    localparam logic [47:0] C_H1   = 48'd14;
    localparam logic [47:0] C_H2   = 48'd15;
    localparam logic [47:0] C_H3   = 48'd16;
    localparam logic [47:0] C_H4   = 48'd17;
    localparam logic [47:0] C_H5   = 48'd18;
    localparam logic [47:0] C_H6   = 48'd19;

    localparam logic [1:0] R0 = 2'd0;
    localparam logic [1:0] R1 = 2'd1;
    localparam logic [1:0] R2 = 2'd2;
    localparam logic [1:0] R3 = 2'd3;

    localparam logic [31:0] HUM_CAP = 32'd419430400;

    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  dst;
        logic [1:0]  a;
        logic [1:0]  b;
        logic [47:0] imm;
    } instr_t;

    typedef struct packed {
        logic [47:0] t;
        logic [47:0] pa;
        logic [47:0] pb;
        logic [47:0] pc;
        logic [31:0] ha;
        logic [39:0] hb;
    } coef_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        dbz;
    } result_t;

    function automatic instr_t mk(input logic [3:0] op, input logic [1:0] dst,
                                  input logic [1:0] a, input logic [1:0] b,
                                  input logic [47:0] imm);
        instr_t i;
        i.op  = op;
        i.dst = dst;
        i.a   = a;
        i.b   = b;
        i.imm = imm;
        return i;
    endfunction

    function automatic instr_t temp_prog(input logic [5:0] idx);
        case (idx)
            6'd0:  return mk(OP_LDC,  R0, R0, R0, C_RAW);
            6'd1:  return mk(OP_ASR,  R1, R0, R0, 48'd3);
            6'd2:  return mk(OP_LDC,  R2, R0, R0, C_T1);
            6'd3:  return mk(OP_SHL,  R3, R2, R0, 48'd1);
            6'd4:  return mk(OP_SUB,  R1, R1, R3, 48'd0);
            6'd5:  return mk(OP_LDC,  R3, R0, R0, C_T2);
            6'd6:  return mk(OP_MUL,  R1, R1, R3, 48'd0);
            6'd7:  return mk(OP_W32,  R1, R1, R0, 48'd0);
            6'd8:  return mk(OP_ASR,  R1, R1, R0, 48'd11);
            6'd9:  return mk(OP_ASR,  R0, R0, R0, 48'd4);
            6'd10: return mk(OP_SUB,  R0, R0, R2, 48'd0);
            6'd11: return mk(OP_MUL,  R0, R0, R0, 48'd0);
            6'd12: return mk(OP_W32,  R0, R0, R0, 48'd0);
            6'd13: return mk(OP_ASR,  R0, R0, R0, 48'd12);
            6'd14: return mk(OP_LDC,  R3, R0, R0, C_T3);
            6'd15: return mk(OP_MUL,  R0, R0, R3, 48'd0);
            6'd16: return mk(OP_W32,  R0, R0, R0, 48'd0);
            6'd17: return mk(OP_ASR,  R0, R0, R0, 48'd14);
            6'd18: return mk(OP_ADD,  R0, R1, R0, 48'd0);
            6'd19: return mk(OP_W32,  R0, R0, R0, 48'd0);
            6'd20: return mk(OP_STF,  R0, R0, R0, 48'd0);
            6'd21: return mk(OP_LDI,  R1, R0, R0, 48'd5);
            6'd22: return mk(OP_MUL,  R0, R0, R1, 48'd0);
            6'd23: return mk(OP_ADDI, R0, R0, R0, 48'd128);
            6'd24: return mk(OP_W32,  R0, R0, R0, 48'd0);
            6'd25: return mk(OP_ASR,  R0, R0, R0, 48'd8);
            default: return mk(OP_END, R0, R0, R0, 48'd0);
        endcase
    endfunction

    function automatic instr_t pres_prog(input logic [5:0] idx);
        case (idx)
            6'd0:  return mk(OP_LDC,  R0, R0, R0, C_FINE);
            6'd1:  return mk(OP_SUBI, R0, R0, R0, 48'd128000);
            6'd2:  return mk(OP_MUL,  R1, R0, R0, 48'd0);
            6'd3:  return mk(OP_LDC,  R2, R0, R0, C_P6);
            6'd4:  return mk(OP_MUL,  R2, R1, R2, 48'd0);
            6'd5:  return mk(OP_LDC,  R3, R0, R0, C_P5);
            6'd6:  return mk(OP_MUL,  R3, R0, R3, 48'd0);
            6'd7:  return mk(OP_SHL,  R3, R3, R0, 48'd17);
            6'd8:  return mk(OP_ADD,  R2, R2, R3, 48'd0);
            6'd9:  return mk(OP_LDC,  R3, R0, R0, C_P4);
            6'd10: return mk(OP_SHL,  R3, R3, R0, 48'd35);
            6'd11: return mk(OP_ADD,  R2, R2, R3, 48'd0);
            6'd12: return mk(OP_LDC,  R3, R0, R0, C_P3);
            6'd13: return mk(OP_MUL,  R1, R1, R3, 48'd0);
            6'd14: return mk(OP_ASR,  R1, R1, R0, 48'd8);
            6'd15: return mk(OP_LDC,  R3, R0, R0, C_P2);
            6'd16: return mk(OP_MUL,  R3, R0, R3, 48'd0);
            6'd17: return mk(OP_SHL,  R3, R3, R0, 48'd12);
            6'd18: return mk(OP_ADD,  R1, R1, R3, 48'd0);
            6'd19: return mk(OP_ADDI, R1, R1, R0, 48'h8000_0000_0000);
            6'd20: return mk(OP_LDC,  R3, R0, R0, C_P1);
            6'd21: return mk(OP_MUL,  R1, R1, R3, 48'd0);
            6'd22: return mk(OP_ASR,  R1, R1, R0, 48'd33);
            6'd23: return mk(OP_CHKZ, R0, R1, R0, 48'd0);
            6'd24: return mk(OP_LDC,  R0, R0, R0, C_RAW);
            6'd25: return mk(OP_LDI,  R3, R0, R0, 48'd1048576);
            6'd26: return mk(OP_SUB,  R0, R3, R0, 48'd0);
            6'd27: return mk(OP_SHL,  R0, R0, R0, 48'd31);
            6'd28: return mk(OP_SUB,  R0, R0, R2, 48'd0);
            6'd29: return mk(OP_LDI,  R3, R0, R0, 48'd3125);
            6'd30: return mk(OP_MUL,  R0, R0, R3, 48'd0);
            6'd31: return mk(OP_DIV,  R0, R0, R1, 48'd0);
            6'd32: return mk(OP_ASR,  R1, R0, R0, 48'd13);
            6'd33: return mk(OP_LDC,  R3, R0, R0, C_P9);
            6'd34: return mk(OP_MUL,  R3, R3, R1, 48'd0);
            6'd35: return mk(OP_MUL,  R3, R3, R1, 48'd0);
            6'd36: return mk(OP_ASR,  R3, R3, R0, 48'd25);
            6'd37: return mk(OP_LDC,  R2, R0, R0, C_P8);
            6'd38: return mk(OP_MUL,  R2, R2, R0, 48'd0);
            6'd39: return mk(OP_ASR,  R2, R2, R0, 48'd19);
            6'd40: return mk(OP_ADD,  R0, R0, R3, 48'd0);
            6'd41: return mk(OP_ADD,  R0, R0, R2, 48'd0);
            6'd42: return mk(OP_ASR,  R0, R0, R0, 48'd8);
            6'd43: return mk(OP_LDC,  R3, R0, R0, C_P7);
            6'd44: return mk(OP_SHL,  R3, R3, R0, 48'd4);
            6'd45: return mk(OP_ADD,  R0, R0, R3, 48'd0);
            6'd46: return mk(OP_SATP, R0, R0, R0, 48'd0);
            default: return mk(OP_END, R0, R0, R0, 48'd0);
        endcase
    endfunction

    function automatic instr_t hum_prog(input logic [5:0] idx);
        case (idx)
            6'd0:  return mk(OP_LDC,  R0, R0, R0, C_FINE);
            6'd1:  return mk(OP_SUBI, R0, R0, R0, 48'd76800);
            6'd2:  return mk(OP_LDC,  R1, R0, R0, C_RAW);
            6'd3:  return mk(OP_SHL,  R1, R1, R0, 48'd14);
            6'd4:  return mk(OP_LDC,  R2, R0, R0, C_H4);
            6'd5:  return mk(OP_SHL,  R2, R2, R0, 48'd20);
            6'd6:  return mk(OP_SUB,  R1, R1, R2, 48'd0);
            6'd7:  return mk(OP_LDC,  R2, R0, R0, C_H5);
            6'd8:  return mk(OP_MUL,  R2, R2, R0, 48'd0);
            6'd9:  return mk(OP_SUB,  R1, R1, R2, 48'd0);
            6'd10: return mk(OP_ADDI, R1, R1, R0, 48'd16384);
            6'd11: return mk(OP_W32,  R1, R1, R0, 48'd0);
            6'd12: return mk(OP_ASR,  R1, R1, R0, 48'd15);
            6'd13: return mk(OP_LDC,  R2, R0, R0, C_H6);
            6'd14: return mk(OP_MUL,  R2, R0, R2, 48'd0);
            6'd15: return mk(OP_W32,  R2, R2, R0, 48'd0);
            6'd16: return mk(OP_ASR,  R2, R2, R0, 48'd10);
            6'd17: return mk(OP_LDC,  R3, R0, R0, C_H3);
            6'd18: return mk(OP_MUL,  R3, R0, R3, 48'd0);
            6'd19: return mk(OP_W32,  R3, R3, R0, 48'd0);
            6'd20: return mk(OP_ASR,  R3, R3, R0, 48'd11);
            6'd21: return mk(OP_ADDI, R3, R3, R0, 48'd32768);
            6'd22: return mk(OP_MUL,  R2, R2, R3, 48'd0);
            6'd23: return mk(OP_W32,  R2, R2, R0, 48'd0);
            6'd24: return mk(OP_ASR,  R2, R2, R0, 48'd10);
            6'd25: return mk(OP_ADDI, R2, R2, R0, 48'd2097152);
            6'd26: return mk(OP_LDC,  R3, R0, R0, C_H2);
            6'd27: return mk(OP_MUL,  R2, R2, R3, 48'd0);
            6'd28: return mk(OP_ADDI, R2, R2, R0, 48'd8192);
            6'd29: return mk(OP_W32,  R2, R2, R0, 48'd0);
            6'd30: return mk(OP_ASR,  R2, R2, R0, 48'd14);
            6'd31: return mk(OP_MUL,  R0, R1, R2, 48'd0);
            6'd32: return mk(OP_W32,  R0, R0, R0, 48'd0);
            6'd33: return mk(OP_ASR,  R1, R0, R0, 48'd15);
            6'd34: return mk(OP_MUL,  R1, R1, R1, 48'd0);
            6'd35: return mk(OP_W32,  R1, R1, R0, 48'd0);
            6'd36: return mk(OP_ASR,  R1, R1, R0, 48'd7);
            6'd37: return mk(OP_LDC,  R2, R0, R0, C_H1);
            6'd38: return mk(OP_MUL,  R1, R1, R2, 48'd0);
            6'd39: return mk(OP_W32,  R1, R1, R0, 48'd0);
            6'd40: return mk(OP_ASR,  R1, R1, R0, 48'd4);
            6'd41: return mk(OP_SUB,  R0, R0, R1, 48'd0);
            6'd42: return mk(OP_CLMP, R0, R0, R0, 48'd0);
            default: return mk(OP_END, R0, R0, R0, 48'd0);
        endcase
    endfunction

endpackage

/* rtl/ecu_mul.sv */
// Iterative 64-bit multiplier, modulo 2^64, one 16-bit digit per cycle
`timescale 1ns / 1ps
module ecu_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        busy,
    output logic        done,
    output logic [63:0] prod
);
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [1:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [79:0] part;

    assign part = a_reg * b_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + part[63:0];
            a_reg   <= {a_reg[47:0], 16'd0};
            b_reg   <= {16'd0, b_reg[63:16]};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;
endmodule

/* rtl/ecu_div.sv */
// Restoring signed 64-bit divider, one quotient bit per cycle, truncating
`timescale 1ns / 1ps
module ecu_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        busy,
    output logic        done,
    output logic [63:0] quot
);
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] den_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] trial;

    assign trial = {rem_reg, quo_reg[63]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 64'd0;
            quo_reg <= num[63] ? (64'd0 - num) : num;
            den_reg <= den[63] ? (64'd0 - den) : den;
            neg_reg <= num[63] ^ den[63];
        end
        else if (busy_reg)
        begin
            if (!trial[64])
                rem_reg <= trial[63:0];
            else
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
            quo_reg <= {quo_reg[62:0], ~trial[64]};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = neg_reg ? (64'd0 - quo_reg) : quo_reg;
endmodule

/* rtl/ecu_core.sv */
// Sequencer, working registers and ALU that run the compensation microprograms
`timescale 1ns / 1ps
module ecu_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      kind,
    input  logic [19:0]     raw,
    input  ecu_pkg::coef_t  coef,
    input  logic            out_free,
    output logic            idle,
    output logic            res_valid,
    output ecu_pkg::result_t res
);
    import ecu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  state_reg;
    logic [5:0]  pc_reg;
    logic [1:0]  kind_reg;
    logic [19:0] raw_reg;
    logic [31:0] fine_reg;
    logic [31:0] value_reg;
    logic        dbz_reg;
    logic [63:0] r0_reg;
    logic [63:0] r1_reg;
    logic [63:0] r2_reg;
    logic [63:0] r3_reg;

    instr_t      ins;
    logic [63:0] va;
    logic [63:0] vb;
    logic [63:0] coef_val;
    logic [63:0] alu;
    logic [63:0] wb_data;
    logic        wb_en;
    logic        mul_start;
    logic        mul_busy;
    logic        mul_done;
    logic [63:0] mul_prod;
    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [63:0] div_quot;
    logic [31:0] clamp_w;

    function automatic logic [63:0] pick(input logic [1:0] sel, input logic [63:0] x0,
                                         input logic [63:0] x1, input logic [63:0] x2,
                                         input logic [63:0] x3);
        case (sel)
            R0:      return x0;
            R1:      return x1;
            R2:      return x2;
            default: return x3;
        endcase
    endfunction

    always_comb
    begin
        case (kind_reg)
            KIND_TEMP: ins = temp_prog(pc_reg);
            KIND_PRES: ins = pres_prog(pc_reg);
            KIND_HUM:  ins = hum_prog(pc_reg);
            default:   ins = mk(OP_END, R0, R0, R0, 48'd0);
        endcase
    end

    assign va = pick(ins.a, r0_reg, r1_reg, r2_reg, r3_reg);
    assign vb = pick(ins.b, r0_reg, r1_reg, r2_reg, r3_reg);

    always_comb
    begin
        case (ins.imm)
            C_RAW:   coef_val = {44'd0, raw_reg};
            C_FINE:  coef_val = {{32{fine_reg[31]}}, fine_reg};
            C_T1:    coef_val = {48'd0, coef.t[15:0]};
            C_T2:    coef_val = {{48{coef.t[31]}}, coef.t[31:16]};
            C_T3:    coef_val = {{48{coef.t[47]}}, coef.t[47:32]};
            C_P1:    coef_val = {48'd0, coef.pa[15:0]};
            C_P2:    coef_val = {{48{coef.pa[31]}}, coef.pa[31:16]};
            C_P3:    coef_val = {{48{coef.pa[47]}}, coef.pa[47:32]};
            C_P4:    coef_val = {{48{coef.pb[15]}}, coef.pb[15:0]};
            C_P5:    coef_val = {{48{coef.pb[31]}}, coef.pb[31:16]};
            C_P6:    coef_val = {{48{coef.pb[47]}}, coef.pb[47:32]};
            C_P7:    coef_val = {{48{coef.pc[15]}}, coef.pc[15:0]};
            C_P8:    coef_val = {{48{coef.pc[31]}}, coef.pc[31:16]};
            C_P9:    coef_val = {{48{coef.pc[47]}}, coef.pc[47:32]};
            C_H1:    coef_val = {56'd0, coef.ha[7:0]};
            C_H2:    coef_val = {{48{coef.ha[23]}}, coef.ha[23:8]};
            C_H3:    coef_val = {56'd0, coef.ha[31:24]};
            C_H4:    coef_val = {{48{coef.hb[15]}}, coef.hb[15:0]};
            C_H5:    coef_val = {{48{coef.hb[31]}}, coef.hb[31:16]};
            C_H6:    coef_val = {{56{coef.hb[39]}}, coef.hb[39:32]};
            default: coef_val = 64'd0;
        endcase
    end

    assign clamp_w = va[31] ? 32'd0 : ((va[31:0] > HUM_CAP) ? HUM_CAP : va[31:0]);

    always_comb
    begin
        case (ins.op)
            OP_LDC:  alu = coef_val;
            OP_LDI:  alu = {16'd0, ins.imm};
            OP_ADD:  alu = va + vb;
            OP_SUB:  alu = va - vb;
            OP_ADDI: alu = va + {16'd0, ins.imm};
            OP_SUBI: alu = va - {16'd0, ins.imm};
            OP_SHL:  alu = va << ins.imm[5:0];
            OP_ASR:  alu = $signed(va) >>> ins.imm[5:0];
            OP_W32:  alu = {{32{va[31]}}, va[31:0]};
            OP_SATP:
            begin
                if (va[63] && !(&va[62:31]))
                    alu = 64'hFFFF_FFFF_8000_0000;
                else if (!va[63] && (|va[62:31]))
                    alu = 64'h0000_0000_7FFF_FFFF;
                else
                    alu = {{32{va[31]}}, va[31:0]};
            end
            OP_CLMP: alu = {44'd0, clamp_w[31:12]};
            default: alu = va;
        endcase
    end

    assign mul_start = (state_reg == S_EXEC) && (ins.op == OP_MUL);
    assign div_start = (state_reg == S_EXEC) && (ins.op == OP_DIV);

    always_comb
    begin
        wb_en   = 1'b0;
        wb_data = alu;
        if (state_reg == S_MUL && mul_done)
        begin
            wb_en   = 1'b1;
            wb_data = mul_prod;
        end
        else if (state_reg == S_DIV && div_done)
        begin
            wb_en   = 1'b1;
            wb_data = div_quot;
        end
        else if (state_reg == S_EXEC)
        begin
            case (ins.op)
                OP_MUL, OP_DIV, OP_CHKZ, OP_STF, OP_END: wb_en = 1'b0;
                default:                                 wb_en = 1'b1;
            endcase
        end
    end

    ecu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (va),
        .b     (vb),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ecu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (va),
        .den   (vb),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= 6'd0;
            kind_reg  <= KIND_TEMP;
            fine_reg  <= 32'd0;
            dbz_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg  <= kind;
                        pc_reg    <= 6'd0;
                        dbz_reg   <= 1'b0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    case (ins.op)
                        OP_MUL: state_reg <= S_MUL;
                        OP_DIV: state_reg <= S_DIV;
                        OP_END: state_reg <= S_DONE;
                        OP_CHKZ:
                        begin
                            if (va == 64'd0)
                            begin
                                dbz_reg   <= 1'b1;
                                state_reg <= S_DONE;
                            end
                            else
                                pc_reg <= pc_reg + 6'd1;
                        end
                        OP_STF:
                        begin
                            fine_reg <= va[31:0];
                            pc_reg   <= pc_reg + 6'd1;
                        end
                        default: pc_reg <= pc_reg + 6'd1;
                    endcase
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        pc_reg    <= pc_reg + 6'd1;
                        state_reg <= S_EXEC;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        pc_reg    <= pc_reg + 6'd1;
                        state_reg <= S_EXEC;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC && ins.op == OP_END)
            value_reg <= (kind_reg == KIND_NONE) ? 32'd0 : va[31:0];
        else if (state_reg == S_EXEC && ins.op == OP_CHKZ && va == 64'd0)
            value_reg <= 32'd0;
        if (state_reg == S_IDLE && start)
            raw_reg <= raw;
        if (wb_en)
        begin
            case (ins.dst)
                R0:      r0_reg <= wb_data;
                R1:      r1_reg <= wb_data;
                R2:      r2_reg <= wb_data;
                default: r3_reg <= wb_data;
            endcase
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE) && out_free;
    assign res.kind  = kind_reg;
    assign res.value = value_reg;
    assign res.dbz   = dbz_reg;

`ifndef NO_ASSERTIONS
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_busy && div_busy))
        else $error("multiplier and divider busy together");

    a_fine_only_temp: assert property (@(posedge clk) disable iff (!rst_n)
        (fine_reg != $past(fine_reg)) |-> ($past(kind_reg) == KIND_TEMP))
        else $error("fine temperature changed outside a temperature transaction");

    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (mul_busy || mul_done))
        else $error("waiting on an idle multiplier");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_busy || div_done))
        else $error("waiting on an idle divider");

    a_dbz_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.dbz |-> (res.kind == KIND_PRES) && (res.value == 32'd0))
        else $error("divide flag on a non-pressure transaction");
`endif
endmodule

/* rtl/env_sensor_compensation_unit.sv */
// Top level: calibration registers, input handshake and output register
`timescale 1ns / 1ps
// Applies the factory calibration formulas of a barometric sensor to one raw
// 20-bit reading per transaction: temperature (0.01 degC, also updates the
// stored fine temperature), pressure (Q24.8 Pa, saturated, zero divisor gives
// 0 with divide_by_zero set) or humidity (Q22.10 %RH, 0..102400). Work runs
// as a microprogram over one shared 64-bit multiplier and a one-bit-per-cycle
// 64-bit divider; in_ready is high only while no transaction is in progress.
// A finished result waits in the output register until taken. Coefficients
// are written by index through the cfg port.
module env_sensor_compensation_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [19:0] raw_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic signed [31:0] result_value,
    output logic        divide_by_zero
);
    import ecu_pkg::*;

    coef_t   coef_reg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    core_idle;
    logic    res_valid;
    logic    out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEMP:   coef_reg.t  <= cfg_wdata;
                CFG_PRES_A: coef_reg.pa <= cfg_wdata;
                CFG_PRES_B: coef_reg.pb <= cfg_wdata;
                CFG_PRES_C: coef_reg.pc <= cfg_wdata;
                CFG_HUM_A:  coef_reg.ha <= cfg_wdata[31:0];
                CFG_HUM_B:  coef_reg.hb <= cfg_wdata[39:0];
                default:    ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = core_idle;

    ecu_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && core_idle),
        .kind      (req_type),
        .raw       (raw_sample),
        .coef      (coef_reg),
        .out_free  (out_free),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_reg.kind;
    assign result_value   = out_reg.value;
    assign divide_by_zero = out_reg.dbz;
endmodule

/* tb/sv/tb_top.sv */
// Testbench for the sensor compensation unit: predicted results versus the block
`timescale 1ns / 1ps
module tb_top;
    import ecu_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [19:0] raw_sample;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic signed [31:0] result_value;
    logic        divide_by_zero;

    env_sensor_compensation_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .raw_sample(raw_sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .result_value(result_value),
        .divide_by_zero(divide_by_zero)
    );

    localparam int WATCHDOG_LIMIT = 20000;

    logic [47:0] coef_t_reg, coef_pa, coef_pb, coef_pc;
    logic [31:0] coef_ha;
    logic [39:0] coef_hb;
    logic [31:0] fine_temp;
    result_t     expected_results[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          timed_out;
    int          stall_mode;

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] asr32(logic [31:0] v, int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] v, int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [31:0] calc_temperature(logic [19:0] raw);
        logic [31:0] t1, t2, t3, x, v1, d, v2;
        t1 = {16'd0, coef_t_reg[15:0]};
        t2 = {{16{coef_t_reg[31]}}, coef_t_reg[31:16]};
        t3 = {{16{coef_t_reg[47]}}, coef_t_reg[47:32]};
        x = {12'd0, raw} >> 3;
        x = x - (t1 << 1);
        v1 = asr32(x * t2, 11);
        d = ({12'd0, raw} >> 4) - t1;
        v2 = asr32(asr32(d * d, 12) * t3, 14);
        fine_temp = v1 + v2;
        return asr32(fine_temp * 32'd5 + 32'd128, 8);
    endfunction

    function automatic logic [31:0] calc_pressure(logic [19:0] raw, output logic dbz);
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, p, h, ma, mb, q;
        p1 = {48'd0, coef_pa[15:0]};
        p2 = sx16(coef_pa[31:16]);
        p3 = sx16(coef_pa[47:32]);
        p4 = sx16(coef_pb[15:0]);
        p5 = sx16(coef_pb[31:16]);
        p6 = sx16(coef_pb[47:32]);
        p7 = sx16(coef_pc[15:0]);
        p8 = sx16(coef_pc[31:16]);
        p9 = sx16(coef_pc[47:32]);
        v1 = {{32{fine_temp[31]}}, fine_temp} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 64'd0)
        begin
            dbz = 1'b1;
            return 32'd0;
        end
        dbz = 1'b0;
        p = 64'd1048576 - {44'd0, raw};
        p = ((p << 31) - v2) * 64'd3125;
        ma = p[63] ? -p : p;
        mb = v1[63] ? -v1 : v1;
        q = ma / mb;
        p = (p[63] != v1[63]) ? -q : q;
        h = asr64(p, 13);
        v1 = asr64(p9 * h * h, 25);
        v2 = asr64(p8 * p, 19);
        p = asr64(p + v1 + v2, 8) + (p7 << 4);
        if ($signed(p) > 64'sh7FFF_FFFF)
            return 32'h7FFF_FFFF;
        if ($signed(p) < -64'sh8000_0000)
            return 32'h8000_0000;
        return p[31:0];
    endfunction

    function automatic logic [31:0] calc_humidity(logic [19:0] raw);
        logic [31:0] h1, h2, h3, h4, h5, h6, v, a, b, s;
        h1 = {24'd0, coef_ha[7:0]};
        h2 = {{16{coef_ha[23]}}, coef_ha[23:8]};
        h3 = {24'd0, coef_ha[31:24]};
        h4 = {{16{coef_hb[15]}}, coef_hb[15:0]};
        h5 = {{16{coef_hb[31]}}, coef_hb[31:16]};
        h6 = {{24{coef_hb[39]}}, coef_hb[39:32]};
        v = fine_temp - 32'd76800;
        a = asr32(({12'd0, raw} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
        b = asr32(v * h6, 10) * (asr32(v * h3, 11) + 32'd32768);
        b = asr32(b, 10) + 32'd2097152;
        b = asr32(b * h2 + 32'd8192, 14);
        v = a * b;
        s = asr32(v, 15);
        v = v - asr32(asr32(s * s, 7) * h1, 4);
        if (v[31])
            v = 32'd0;
        if (v > HUM_CAP)
            v = HUM_CAP;
        return v >> 12;
    endfunction

    function automatic result_t compensate(logic [1:0] kind, logic [19:0] raw);
        result_t r;
        logic    dbz;
        r.kind  = kind;
        r.value = 32'd0;
        r.dbz   = 1'b0;
        case (kind)
            KIND_TEMP: r.value = calc_temperature(raw);
            KIND_PRES:
            begin
                r.value = calc_pressure(raw, dbz);
                r.dbz   = dbz;
            end
            KIND_HUM:  r.value = calc_humidity(raw);
            default: ;
        endcase
        return r;
    endfunction

    task automatic write_coeff(logic [2:0] idx, logic [47:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_TEMP:   coef_t_reg = data;
            CFG_PRES_A: coef_pa = data;
            CFG_PRES_B: coef_pb = data;
            CFG_PRES_C: coef_pc = data;
            CFG_HUM_A:  coef_ha = data[31:0];
            CFG_HUM_B:  coef_hb = data[39:0];
            default: ;
        endcase
    endtask

    task automatic send_reading(logic [1:0] kind, logic [19:0] raw);
        in_valid   <= 1'b1;
        req_type   <= kind;
        raw_sample <= raw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(compensate(kind, raw));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom_range(65535, 0)), $urandom()};
    endfunction

    task automatic load_typical();
        write_coeff(CFG_TEMP,   {16'd50, 16'd26435, 16'd27504});
        write_coeff(CFG_PRES_A, {16'hD0D0, 16'hD68E, 16'd36477});
        write_coeff(CFG_PRES_B, {16'hFFF9, 16'hFF4A, 16'd2855});
        write_coeff(CFG_PRES_C, {16'd6000, 16'hC108, 16'd140});
        write_coeff(CFG_HUM_A,  {8'd0, 16'd359, 8'd75});
        write_coeff(CFG_HUM_B,  {8'd30, 16'd50, 16'd313});
    endtask

    task automatic test_zero_coeffs();
        send_reading(KIND_TEMP, 20'd0);
        send_reading(KIND_PRES, 20'd0);
        send_reading(KIND_HUM, 20'hFFFFF);
        send_reading(KIND_NONE, 20'h12345);
        drain();
    endtask

    task automatic test_directed();
        load_typical();
        cfg_we <= 1'b0;
        send_reading(KIND_TEMP, 20'd519888);
        send_reading(KIND_PRES, 20'd415148);
        send_reading(KIND_HUM, 20'd27000);
        send_reading(KIND_TEMP, 20'hFFFFF);
        send_reading(KIND_PRES, 20'd0);
        send_reading(KIND_PRES, 20'hFFFFF);
        send_reading(KIND_HUM, 20'hFFFFF);
        send_reading(KIND_HUM, 20'd0);
        send_reading(KIND_TEMP, 20'd0);
        send_reading(KIND_PRES, 20'h80000);
        send_reading(KIND_NONE, 20'hFFFFF);
        drain();
        write_coeff(CFG_TEMP,   48'hFFFF_FFFF_FFFF);
        write_coeff(CFG_PRES_A, 48'hFFFF_FFFF_FFFF);
        write_coeff(CFG_PRES_B, 48'hFFFF_FFFF_FFFF);
        write_coeff(CFG_PRES_C, 48'hFFFF_FFFF_FFFF);
        write_coeff(CFG_HUM_A,  48'hFFFF_FFFF);
        write_coeff(CFG_HUM_B,  48'hFF_FFFF_FFFF);
        cfg_we <= 1'b0;
        send_reading(KIND_TEMP, 20'hFFFFF);
        send_reading(KIND_PRES, 20'h55555);
        send_reading(KIND_HUM, 20'hAAAAA);
        send_reading(KIND_TEMP, 20'h0000F);
        send_reading(KIND_PRES, 20'hFFFFF);
        send_reading(KIND_HUM, 20'h00001);
        drain();
        write_coeff(CFG_PRES_A, {16'h7FFF, 16'h8000, 16'd0});
        cfg_we <= 1'b0;
        send_reading(KIND_PRES, 20'd1000);
        drain();
    endtask

    task automatic test_random(int phases, int per_phase);
        logic [1:0] kind;
        for (int ph = 0; ph < phases; ph++)
        begin
            if (ph % 3 == 0)
                load_typical();
            else
                for (int r = 0; r < 6; r++)
                    write_coeff(3'(r), rand48());
            if ($urandom_range(3, 0) == 0)
                write_coeff(3'($urandom_range(7, 6)), rand48());
            cfg_we <= 1'b0;
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(9, 0) == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(12, 1)) @(posedge clk);
                end
                kind = ($urandom_range(19, 0) == 0) ? KIND_NONE : 2'($urandom_range(2, 0));
                send_reading(kind, 20'($urandom()));
            end
            drain();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_mode == 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(3, 0) != 0);
    end

    always @(posedge clk)
    begin
        if ($urandom_range(299, 0) == 0)
            stall_mode <= $urandom_range(1, 0);
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: kind %0d value %0d",
                             result_kind, result_value);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result_kind !== exp_r.kind || result_value !== exp_r.value
                    || divide_by_zero !== exp_r.dbz)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp kind %0d value %0d dbz %0b, got %0d %0d %0b",
                                 exp_r.kind, $signed(exp_r.value), exp_r.dbz,
                                 result_kind, result_value, divide_by_zero);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("env_sensor_compensation_unit test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = 3'd0;
        cfg_wdata  = 48'd0;
        in_valid   = 1'b0;
        req_type   = 2'd0;
        raw_sample = 20'd0;
        out_ready  = 1'b0;
        stall_mode = 0;
        idle_cycles = 0;
        timed_out  = 1'b0;
        mismatch_count = 0;
        coef_t_reg = 48'd0;
        coef_pa    = 48'd0;
        coef_pb    = 48'd0;
        coef_pc    = 48'd0;
        coef_ha    = 32'd0;
        coef_hb    = 40'd0;
        fine_temp  = 32'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_coeffs();
        test_directed();
        test_random(20, 38);
        drain();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("env_sensor_compensation_unit test passed");
        else
            $display("env_sensor_compensation_unit test failed");
        $finish;
    end
endmodule
